@@ rtl/core/ppu_pkg.sv @@
package ppu_pkg;

  // Default sizes for the top level.
  localparam int DEF_PALETTE_ENTRIES = 256;
  localparam int DEF_MAX_ROW_PIXELS  = 8192;

  // Configuration port shape.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 14;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_COLOR_MODE   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_DEPTH = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ROW_PIXELS   = 2'd2;

  // Color modes.
  localparam logic [2:0] MODE_GRAY       = 3'd0;
  localparam logic [2:0] MODE_RGB        = 3'd1;
  localparam logic [2:0] MODE_PALETTE    = 3'd2;
  localparam logic [2:0] MODE_GRAY_ALPHA = 3'd3;
  localparam logic [2:0] MODE_RGBA       = 3'd4;

  // Input item kinds.
  localparam logic OP_DATA    = 1'b0;
  localparam logic OP_PALETTE = 1'b1;

  // Channel position within a multi-channel pixel.
  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;
  localparam logic [1:0] CH_ALPHA = 2'd3;

  // Register reset values.
  localparam logic [2:0]  RESET_COLOR_MODE   = MODE_RGB;
  localparam logic [3:0]  RESET_SAMPLE_DEPTH = 4'd8;
  localparam logic [13:0] RESET_ROW_PIXELS   = 14'd1;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
    logic [7:0] entry_index;
    logic [7:0] entry_red;
    logic [7:0] entry_green;
    logic [7:0] entry_blue;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_of_run;
    logic       row_end;
  } out_item_t;

endpackage

@@ rtl/core/png_pixel_unpack.sv @@
// A data byte passes the unpack stage, the lookup stage and the output register in that order.
// Throughput: one transaction per cycle on each side while the output is not stalled; a packed
// byte yields up to eight pixels, one per cycle, and in gray+alpha mode each dropped alpha
// sample takes a step of its own in the unpack stage. Palette writes do not wait for the output.
// Reset loads rgb mode, sample depth 8 and one-pixel rows, and clears the channel
// position, held colors and column count; the palette memory holds garbage until written.
module png_pixel_unpack import ppu_pkg::*; #(
  parameter int PALETTE_ENTRIES = DEF_PALETTE_ENTRIES,
  parameter int MAX_ROW_PIXELS  = DEF_MAX_ROW_PIXELS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   byte_valid,
  output logic                   byte_ready,
  input  in_item_t               byte_item,
  output logic                   pixel_valid,
  input  logic                   pixel_ready,
  output out_item_t              pixel_item,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int AW = $clog2(PALETTE_ENTRIES);
  localparam int CW = (MAX_ROW_PIXELS > 1) ? $clog2(MAX_ROW_PIXELS) : 1;
  localparam int LW = $clog2(MAX_ROW_PIXELS + 1);
  localparam int RW = (LW > CFG_DATA_W) ? LW : CFG_DATA_W;

  // Configuration registers.
  logic [2:0]            color_mode;
  logic [3:0]            sample_depth;
  logic [CFG_DATA_W-1:0] row_pixels;

  // Pixel state.
  logic [1:0]    channel_index, channel_index_next;
  logic [7:0]    held_red, held_red_next;
  logic [7:0]    held_green, held_green_next;
  logic [CW-1:0] column_count, column_count_next;

  // Unpack stage.
  logic      a_valid;
  in_item_t  a_item;
  logic [2:0] a_slot;
  logic      a_is_wr;
  logic      a_fire;
  logic      adv;

  // Lookup stage.
  logic       b_valid;
  logic       b_pal;
  logic       b_oor;
  logic [7:0] b_red, b_green, b_blue;
  logic       b_last, b_end;

  // Step results.
  logic          step_emit, step_last, step_pal, step_oor, step_lor;
  logic [7:0]    step_red, step_green, step_blue;
  logic [3:0]    depth;
  logic [2:0]    last_slot;
  logic [2:0]    shift_amt;
  logic [7:0]    shifted;
  logic [7:0]    sample_raw;
  logic [7:0]    sample_gray;
  logic [RW-1:0] row_len;
  logic [RW:0]   col_inc;
  logic          row_hit;

  // Palette memory interface.
  logic          ram_we, ram_re;
  logic [23:0]   ram_rdata;

  // Register writes from the configuration port.
  always_ff @(posedge clk) begin
    if (rst) begin
      color_mode   <= RESET_COLOR_MODE;
      sample_depth <= RESET_SAMPLE_DEPTH;
      row_pixels   <= RESET_ROW_PIXELS;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COLOR_MODE:   color_mode   <= cfg_data[2:0];
        CFG_SAMPLE_DEPTH: sample_depth <= cfg_data[3:0];
        CFG_ROW_PIXELS:   row_pixels   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective row length, clamped into one to the maximum.
  always_comb begin
    row_len = RW'(row_pixels);
    if (row_pixels == '0) begin
      row_len = RW'(1);
    end else if (RW'(row_pixels) > RW'(MAX_ROW_PIXELS)) begin
      row_len = RW'(MAX_ROW_PIXELS);
    end
    col_inc = (RW + 1)'(column_count) + (RW + 1)'(1);
    row_hit = col_inc >= {1'b0, row_len};
  end

  // Sample extraction: depth, slot position and the shifted byte.
  always_comb begin
    case (sample_depth)
      4'd1, 4'd2, 4'd4: depth = sample_depth;
      default:          depth = 4'd8;
    endcase
    case (depth)
      4'd1: begin
        last_slot = 3'd7;
        shift_amt = a_slot;
      end
      4'd2: begin
        last_slot = 3'd3;
        shift_amt = {a_slot[1:0], 1'b0};
      end
      4'd4: begin
        last_slot = 3'd1;
        shift_amt = {a_slot[0], 2'b00};
      end
      default: begin
        last_slot = 3'd0;
        shift_amt = 3'd0;
      end
    endcase
    shifted = a_item.data_byte << shift_amt;
    case (depth)
      4'd1: begin
        sample_raw  = {7'd0, shifted[7]};
        sample_gray = {8{shifted[7]}};
      end
      4'd2: begin
        sample_raw  = {6'd0, shifted[7:6]};
        sample_gray = {4{shifted[7:6]}};
      end
      4'd4: begin
        sample_raw  = {4'd0, shifted[7:4]};
        sample_gray = {2{shifted[7:4]}};
      end
      default: begin
        sample_raw  = shifted;
        sample_gray = shifted;
      end
    endcase
  end

  assign a_is_wr = (a_item.op == OP_PALETTE);
  assign adv     = !pixel_valid || pixel_ready;
  assign a_fire  = a_valid && (a_is_wr || adv);

  // One step of the unpack stage: consume a channel byte or one packed sample.
  always_comb begin
    step_emit          = 1'b0;
    step_last          = 1'b1;
    step_pal           = 1'b0;
    step_oor           = 1'b0;
    step_lor           = 1'b0;
    step_red           = 8'd0;
    step_green         = 8'd0;
    step_blue          = 8'd0;
    channel_index_next = channel_index;
    held_red_next      = held_red;
    held_green_next    = held_green;
    if (!a_is_wr) begin
      case (color_mode)
        MODE_RGB, MODE_RGBA: begin
          if (channel_index == CH_RED) begin
            held_red_next      = a_item.data_byte;
            channel_index_next = CH_GREEN;
          end else if (channel_index == CH_GREEN) begin
            held_green_next    = a_item.data_byte;
            channel_index_next = CH_BLUE;
          end else if (color_mode == MODE_RGBA && channel_index == CH_ALPHA) begin
            channel_index_next = CH_RED;
          end else begin
            step_emit          = 1'b1;
            step_lor           = 1'b1;
            step_red           = held_red;
            step_green         = held_green;
            step_blue          = a_item.data_byte;
            channel_index_next = (color_mode == MODE_RGBA) ? CH_ALPHA : CH_RED;
          end
        end
        MODE_GRAY, MODE_PALETTE, MODE_GRAY_ALPHA: begin
          step_last = (a_slot == last_slot);
          if (color_mode == MODE_GRAY_ALPHA && channel_index != CH_RED) begin
            // Alpha sample: dropped.
            channel_index_next = CH_RED;
          end else begin
            step_emit  = 1'b1;
            step_pal   = (color_mode == MODE_PALETTE);
            step_oor   = {1'b0, sample_raw} >= 9'(PALETTE_ENTRIES);
            step_red   = sample_gray;
            step_green = sample_gray;
            step_blue  = sample_gray;
            if (color_mode == MODE_GRAY_ALPHA) begin
              // Position one means the alpha sample comes next.
              channel_index_next = CH_GREEN;
              step_lor = row_hit || ({1'b0, a_slot} + 4'd1 >= {1'b0, last_slot});
            end else begin
              step_lor = row_hit || step_last;
            end
            // Row ends inside the byte: the rest is padding.
            if (row_hit && !step_last) begin
              step_last = 1'b1;
              if (color_mode == MODE_GRAY_ALPHA) begin
                channel_index_next = CH_RED;
              end
            end
          end
        end
        default: ;
      endcase
    end
    column_count_next = column_count;
    if (step_emit) begin
      column_count_next = row_hit ? '0 : col_inc[CW-1:0];
    end
  end

  assign byte_ready = !a_valid || (a_fire && step_last);

  // Unpack stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      a_slot  <= 3'd0;
    end else if (byte_valid && byte_ready) begin
      a_valid <= 1'b1;
      a_slot  <= 3'd0;
    end else if (a_fire) begin
      if (step_last) begin
        a_valid <= 1'b0;
      end else begin
        a_slot <= a_slot + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && byte_ready) begin
      a_item <= byte_item;
    end
  end

  // Pixel state updates once per step.
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_index <= CH_RED;
      held_red      <= 8'd0;
      held_green    <= 8'd0;
      column_count  <= '0;
    end else if (a_fire && !a_is_wr) begin
      channel_index <= channel_index_next;
      held_red      <= held_red_next;
      held_green    <= held_green_next;
      column_count  <= column_count_next;
    end
  end

  // Palette writes pass through the unpack stage so they stay ordered with lookups.
  assign ram_we = a_fire && a_is_wr &&
                  ({1'b0, a_item.entry_index} < 9'(PALETTE_ENTRIES));
  assign ram_re = a_fire && step_emit && step_pal;

  ppu_ram #(
    .WIDTH (24),
    .DEPTH (PALETTE_ENTRIES)
  ) u_palette (
    .clk   (clk),
    .we    (ram_we),
    .waddr (a_item.entry_index[AW-1:0]),
    .wdata ({a_item.entry_red, a_item.entry_green, a_item.entry_blue}),
    .re    (ram_re),
    .raddr (sample_raw[AW-1:0]),
    .rdata (ram_rdata)
  );

  // Lookup stage: waits for the palette read data.
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (adv) begin
      b_valid <= a_fire && step_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_pal   <= step_pal;
      b_oor   <= step_oor;
      b_red   <= step_red;
      b_green <= step_green;
      b_blue  <= step_blue;
      b_last  <= step_lor;
      b_end   <= row_hit;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else if (adv) begin
      pixel_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && b_valid) begin
      if (b_pal) begin
        pixel_item.red   <= b_oor ? 8'd0 : ram_rdata[23:16];
        pixel_item.green <= b_oor ? 8'd0 : ram_rdata[15:8];
        pixel_item.blue  <= b_oor ? 8'd0 : ram_rdata[7:0];
      end else begin
        pixel_item.red   <= b_red;
        pixel_item.green <= b_green;
        pixel_item.blue  <= b_blue;
      end
      pixel_item.last_of_run <= b_last;
      pixel_item.row_end     <= b_end;
    end
  end

  // The final pixel of a scanline always closes the run of its byte.
  a_row_end_closes_run: assert property (@(posedge clk) disable iff (rst)
    pixel_valid |-> (!pixel_item.row_end || pixel_item.last_of_run))
    else $error("row end pixel without last_of_run");

  // A palette write and a palette lookup never share a cycle.
  a_no_ram_overlap: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ram_re))
    else $error("palette write and read in the same cycle");

  // A byte with samples still to unpack blocks the input.
  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    (a_valid && !step_last) |-> !byte_ready)
    else $error("input taken while a byte is still unpacking");

  // A pixel sent to the lookup stage reaches the output on the next advance.
  a_lookup_forward: assert property (@(posedge clk) disable iff (rst)
    (b_valid && adv) |=> pixel_valid)
    else $error("lookup stage pixel lost");

endmodule

@@ rtl/core/ppu_ram.sv @@
module ppu_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port, registered read that holds when not enabled.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ verif/tb_png_pixel_unpack.sv @@
module tb_png_pixel_unpack;
  import ppu_pkg::*;

  localparam int PALETTE_SIZE = DEF_PALETTE_ENTRIES;
  localparam int MAX_ROW = DEF_MAX_ROW_PIXELS;
  localparam int SETTLE_CYCLES = 32;
  localparam int LONG_HOLD = 150;
  localparam int RANDOM_ITEMS = 224;
  localparam int CYCLE_LIMIT = 400000;

  logic clk;
  logic rst = 1'b1;
  logic byte_valid = 1'b0;
  logic byte_ready;
  in_item_t byte_item = '0;
  logic pixel_valid;
  logic pixel_ready = 1'b0;
  out_item_t pixel_item;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Predicted decoder state, updated at the edge where each transaction lands.
  logic [23:0] pal_mem [PALETTE_SIZE];
  bit pal_written [PALETTE_SIZE];
  logic [1:0] chan_pos = CH_RED;
  logic [7:0] held_r = '0;
  logic [7:0] held_g = '0;
  int col_cnt = 0;
  logic [2:0] cur_mode = RESET_COLOR_MODE;
  logic [3:0] cur_depth = RESET_SAMPLE_DEPTH;
  logic [13:0] cur_row = RESET_ROW_PIXELS;

  out_item_t expected_pixels [$];
  int failures = 0;
  bit no_gaps = 1'b0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int cycle_count;

  png_pixel_unpack #(
    .PALETTE_ENTRIES(PALETTE_SIZE),
    .MAX_ROW_PIXELS(MAX_ROW)
  ) uut (
    .clk(clk),
    .rst(rst),
    .byte_valid(byte_valid),
    .byte_ready(byte_ready),
    .byte_item(byte_item),
    .pixel_valid(pixel_valid),
    .pixel_ready(pixel_ready),
    .pixel_item(pixel_item),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Effective row length after clamping.
  function automatic int row_limit();
    if (cur_row == 0) return 1;
    if (cur_row > MAX_ROW) return MAX_ROW;
    return int'(cur_row);
  endfunction

  // Depths other than 1, 2 and 4 behave as 8.
  function automatic int sample_bits();
    if (cur_depth == 1 || cur_depth == 2 || cur_depth == 4) return int'(cur_depth);
    return 8;
  endfunction

  // Queues one expected pixel and advances the column; returns 1 at row end.
  function automatic bit push_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    out_item_t p;
    p.red = r;
    p.green = g;
    p.blue = b;
    p.last_of_run = 1'b0;
    p.row_end = (col_cnt + 1 >= row_limit());
    col_cnt = p.row_end ? 0 : col_cnt + 1;
    expected_pixels.push_back(p);
    return p.row_end;
  endfunction

  // Works out the pixels that one accepted transaction produces.
  function automatic void predict_pixels(in_item_t it);
    int n;
    int d;
    int count;
    int scale;
    int v;
    int s;
    bit ended;
    logic [23:0] e;
    logic [7:0] g;
    n = 0;
    if (it.op == OP_PALETTE) begin
      if (it.entry_index < PALETTE_SIZE) begin
        pal_mem[it.entry_index] = {it.entry_red, it.entry_green, it.entry_blue};
        pal_written[it.entry_index] = 1'b1;
      end
      return;
    end
    if (cur_mode == MODE_RGB || cur_mode == MODE_RGBA) begin
      // One byte per channel; the alpha byte is skipped in rgba mode.
      if (chan_pos == CH_RED) begin
        held_r = it.data_byte;
        chan_pos = CH_GREEN;
      end else if (chan_pos == CH_GREEN) begin
        held_g = it.data_byte;
        chan_pos = CH_BLUE;
      end else if (cur_mode == MODE_RGBA && chan_pos == CH_ALPHA) begin
        chan_pos = CH_RED;
      end else begin
        void'(push_pixel(held_r, held_g, it.data_byte));
        n++;
        chan_pos = (cur_mode == MODE_RGBA) ? CH_ALPHA : CH_RED;
      end
    end else if (cur_mode == MODE_GRAY || cur_mode == MODE_PALETTE ||
                 cur_mode == MODE_GRAY_ALPHA) begin
      d = sample_bits();
      count = 8 / d;
      case (d)
        1: scale = 255;
        2: scale = 85;
        4: scale = 17;
        default: scale = 1;
      endcase
      for (s = 0; s < count; s++) begin
        v = (it.data_byte >> (8 - d * (s + 1))) & ((1 << d) - 1);
        // In gray+alpha mode a position other than the first means alpha comes next.
        if (cur_mode == MODE_GRAY_ALPHA) begin
          if (chan_pos != CH_RED) begin
            chan_pos = CH_RED;
            continue;
          end
          chan_pos = CH_GREEN;
        end
        if (cur_mode == MODE_PALETTE) begin
          e = (v < PALETTE_SIZE) ? pal_mem[v] : '0;
          ended = push_pixel(e[23:16], e[15:8], e[7:0]);
        end else begin
          g = 8'(v * scale);
          ended = push_pixel(g, g, g);
        end
        n++;
        // The rest of the byte is padding once the row is complete.
        if (ended && s + 1 < count) begin
          if (cur_mode == MODE_GRAY_ALPHA) chan_pos = CH_RED;
          break;
        end
      end
    end
    if (n > 0) expected_pixels[$].last_of_run = 1'b1;
  endfunction

  function automatic in_item_t data_item(logic [7:0] value);
    in_item_t it;
    it.op = OP_DATA;
    it.data_byte = value;
    it.entry_index = 8'($urandom_range(0, 255));
    it.entry_red = 8'($urandom_range(0, 255));
    it.entry_green = 8'($urandom_range(0, 255));
    it.entry_blue = 8'($urandom_range(0, 255));
    return it;
  endfunction

  function automatic in_item_t palette_item(logic [7:0] idx, logic [23:0] rgb);
    in_item_t it;
    it.op = OP_PALETTE;
    it.data_byte = 8'($urandom_range(0, 255));
    it.entry_index = idx;
    {it.entry_red, it.entry_green, it.entry_blue} = rgb;
    return it;
  endfunction

  // Random data byte; in palette mode every index it holds points at a written entry.
  function automatic logic [7:0] pick_byte();
    int d;
    int v;
    int s;
    logic [7:0] b;
    if (cur_mode != MODE_PALETTE) return 8'($urandom_range(0, 255));
    d = sample_bits();
    b = '0;
    for (s = 0; s < 8 / d; s++) begin
      do v = $urandom_range(0, (1 << d) - 1); while (!pal_written[v]);
      b = (b << d) | 8'(v);
    end
    return b;
  endfunction

  function automatic void compare_field(string name, logic [7:0] want, logic [7:0] seen);
    if (seen !== want) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, seen);
      failures++;
    end
  endfunction

  function automatic void check_pixel(out_item_t got);
    out_item_t want;
    if (expected_pixels.size() == 0) begin
      $display("%0t: unexpected pixel: expected none, actual r=%0d g=%0d b=%0d last=%0d end=%0d",
               $time, got.red, got.green, got.blue, got.last_of_run, got.row_end);
      failures++;
    end else begin
      want = expected_pixels.pop_front();
      compare_field("red", want.red, got.red);
      compare_field("green", want.green, got.green);
      compare_field("blue", want.blue, got.blue);
      compare_field("last_of_run", 8'(want.last_of_run), 8'(got.last_of_run));
      compare_field("row_end", 8'(want.row_end), 8'(got.row_end));
    end
  endfunction

  // Offers one transaction after a random gap and waits for it to be taken.
  task automatic send_byte(in_item_t it);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_item <= it;
    do @(posedge clk); while (byte_ready !== 1'b1);
    predict_pixels(it);
  endtask

  // Drains all pending pixels and lets trailing work finish.
  task automatic settle();
    byte_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, int value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(value);
    @(posedge clk);
    case (idx)
      CFG_COLOR_MODE: cur_mode = 3'(value);
      CFG_SAMPLE_DEPTH: cur_depth = 4'(value);
      CFG_ROW_PIXELS: cur_row = 14'(value);
      default: ;
    endcase
  endtask

  // Reprograms all three registers while the block is idle.
  task automatic set_format(int mode, int depth, int row);
    settle();
    write_reg(CFG_COLOR_MODE, mode);
    write_reg(CFG_SAMPLE_DEPTH, depth);
    write_reg(CFG_ROW_PIXELS, row);
    cfg_we <= 1'b0;
  endtask

  // Registers as left by reset: rgb, one pixel per row.
  task automatic test_reset_format();
    send_byte(data_item(8'h00));
    send_byte(data_item(8'hFF));
    send_byte(data_item(8'h5A));
  endtask

  // Gray at every depth, odd depths, clamped row lengths and a row that ends inside a byte.
  task automatic test_gray_depths();
    set_format(MODE_GRAY, 1, 5);
    send_byte(data_item(8'hB6));
    set_format(MODE_GRAY, 2, 16383);
    send_byte(data_item(8'hE4));
    set_format(MODE_GRAY, 4, 2);
    send_byte(data_item(8'hF0));
    set_format(MODE_GRAY, 0, 0);
    send_byte(data_item(8'h80));
    set_format(MODE_GRAY, 15, 3);
    send_byte(data_item(8'h7F));
  endtask

  task automatic test_palette_lookup();
    set_format(MODE_PALETTE, 2, 7);
    send_byte(palette_item(8'd0, 24'h123456));
    send_byte(palette_item(8'd1, 24'hFFFFFF));
    send_byte(palette_item(8'd2, 24'h000000));
    send_byte(palette_item(8'd3, 24'hA55AC3));
    send_byte(palette_item(8'd255, 24'h807F01));
    send_byte(data_item(8'h1B));
    set_format(MODE_PALETTE, 8, 7);
    send_byte(data_item(8'hFF));
  endtask

  // Alpha samples are dropped; a row ending inside a byte resets the channel.
  task automatic test_gray_alpha();
    set_format(MODE_GRAY_ALPHA, 8, 16383);
    send_byte(data_item(8'h40));
    set_format(MODE_GRAY_ALPHA, 1, 3);
    send_byte(data_item(8'hAA));
    send_byte(data_item(8'h55));
  endtask

  // Rgba gathering, then mode switches that leave a stale channel position.
  task automatic test_rgba_stale();
    set_format(MODE_RGBA, 8, 2);
    send_byte(data_item(8'h11));
    send_byte(data_item(8'h22));
    send_byte(data_item(8'h33));
    send_byte(data_item(8'h44));
    send_byte(data_item(8'h55));
    send_byte(data_item(8'h66));
    send_byte(data_item(8'h77));
    set_format(MODE_RGB, 8, 2);
    send_byte(data_item(8'h99));
    send_byte(data_item(8'hAB));
    set_format(MODE_GRAY_ALPHA, 8, 2);
    send_byte(data_item(8'hEE));
    send_byte(data_item(8'hCC));
  endtask

  task automatic test_unknown_mode();
    set_format(7, 8, 4);
    send_byte(data_item(8'hC3));
  endtask

  // Long receiver hold while the sender keeps pushing depth-1 bytes.
  task automatic test_backpressure();
    set_format(MODE_GRAY, 1, 16383);
    no_gaps = 1'b1;
    hold_requests <= hold_requests + 1;
    repeat (16) send_byte(data_item(8'($urandom_range(0, 255))));
    no_gaps = 1'b0;
  endtask

  // Random formats, each followed by a burst of data bytes and palette writes.
  task automatic test_random_stream();
    int mode;
    int depth;
    int row;
    int burst;
    int done_items;
    done_items = 0;
    while (done_items < RANDOM_ITEMS) begin
      mode = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
      depth = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : (1 << $urandom_range(0, 3));
      case ($urandom_range(0, 9))
        0: row = 0;
        1: row = $urandom_range(MAX_ROW + 1, 16383);
        2: row = $urandom_range(100, MAX_ROW);
        default: row = $urandom_range(1, 24);
      endcase
      set_format(mode, depth, row);
      no_gaps = ($urandom_range(0, 4) == 0);
      burst = $urandom_range(8, 30);
      repeat (burst) begin
        if ($urandom_range(0, 6) == 0)
          send_byte(palette_item(8'($urandom_range(0, 255)), 24'($urandom)));
        else
          send_byte(data_item(pick_byte()));
      end
      done_items += burst;
    end
    no_gaps = 1'b0;
  endtask

  // Pixel sink: random stalls, plus the long hold when one is pending.
  initial begin : pixel_sink
    int stall;
    wait (rst === 1'b0);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 7);
      if (hold_left != 0 || stall != 0) begin
        pixel_ready <= 1'b0;
        while (hold_left != 0) @(posedge clk);
        repeat (stall) @(posedge clk);
      end
      pixel_ready <= 1'b1;
      do @(posedge clk); while (pixel_valid !== 1'b1);
      check_pixel(pixel_item);
    end
  end

  // Counts down the long receiver hold.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_served + 1;
      hold_left <= LONG_HOLD;
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("tb: failure");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_reset_format();
    test_gray_depths();
    test_palette_lookup();
    test_gray_alpha();
    test_rgba_stale();
    test_unknown_mode();
    test_backpressure();
    test_random_stream();
    settle();
    if (failures == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
